[rtl/pvm_pkg.sv]
// shared types, constants and the fade gain table for the pcm voice mixer
// no dependencies; imported by every rtl module of the mixer
package pvm_pkg;

   localparam int NUM_VOICES      = 32;
   localparam int VOICE_BITS      = 5;
   localparam int VOICE_DEPTH     = 8192;
   localparam int SIDX_BITS       = 13;
   localparam int LEN_BITS        = 14;
   localparam int PENDING_DEPTH   = 3;
   localparam int PCNT_BITS       = 2;
   localparam int GAIN_TABLE_SIZE = 256;
   localparam int GAIN_BITS       = 8;
   localparam int STEP_BITS       = 3;
   localparam int POS_BITS        = 25;
   localparam int FADE_BITS       = 24;
   localparam int SAMPLE_BITS     = 16;
   localparam int ADDR_BITS       = VOICE_BITS + SIDX_BITS;
   localparam int STORE_DEPTH     = NUM_VOICES * VOICE_DEPTH;
   localparam int VSUM_BITS       = VOICE_BITS + SAMPLE_BITS + 1;
   localparam int SUM_BITS        = VSUM_BITS + 16;
   localparam int PROD_BITS       = 33;
   localparam int EXP_SCALE       = 544265;
   localparam logic [15:0] GAIN_UNITY = 16'd32767;
   localparam logic [FADE_BITS-1:0] FADE_MAX = {FADE_BITS{1'b1}};

   localparam logic [2:0] REQ_LOAD        = 3'd0;
   localparam logic [2:0] REQ_LENGTH      = 3'd1;
   localparam logic [2:0] REQ_TRIGGER     = 3'd2;
   localparam logic [2:0] REQ_TICK        = 3'd3;
   localparam logic [2:0] REQ_MUSIC_START = 3'd4;
   localparam logic [2:0] REQ_MUSIC_STOP  = 3'd5;
   localparam logic [2:0] REQ_FADE_START  = 3'd6;

   localparam logic [1:0] REG_LOOP_START   = 2'd0;
   localparam logic [1:0] REG_LOOP_END     = 2'd1;
   localparam logic [1:0] REG_LOOPING      = 2'd2;
   localparam logic [1:0] REG_SOUND_ENABLE = 2'd3;

   typedef enum logic [2:0] {
      OP_LOAD, OP_LENGTH, OP_TRIGGER, OP_TICK,
      OP_MUSIC_START, OP_MUSIC_STOP, OP_FADE_START, OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_GAIN, ST_VOICE, ST_DRAIN, ST_MUL, ST_SAT, ST_OUT
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic [VOICE_BITS-1:0]    voice;
      logic [SIDX_BITS-1:0]     sidx;
      logic signed [15:0]       sval;
      logic [LEN_BITS-1:0]      vlen;
      logic signed [15:0]       ml;
      logic signed [15:0]       mr;
      logic                     chunk;
      logic [FADE_BITS-1:0]     fade;
   } cmd_type;

   typedef struct packed {
      logic [POS_BITS-1:0] loop_start;
      logic [POS_BITS-1:0] loop_end;
      logic                looping;
      logic                sound_enable;
   } cfg_type;

   typedef logic [15:0] gain_table_type [GAIN_TABLE_SIZE];

   function automatic logic [63:0] isqrt64(logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (b > n) b = b >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (b != 64'd0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic gain_table_type build_gain_table();
      gain_table_type t;
      logic [63:0] roots [16];
      logic [63:0] e;
      logic [63:0] acc;
      logic [63:0] g;
      logic [15:0] f;
      int          sh;
      roots[0] = isqrt64(64'd1 << 59);
      for (int b = 1; b < 16; b++) roots[b] = isqrt64(roots[b-1] << 30);
      for (int i = 0; i < GAIN_TABLE_SIZE; i++) begin
         e   = (64'(i) * 64'(EXP_SCALE)) / GAIN_TABLE_SIZE;
         f   = e[15:0];
         sh  = 15 + int'(e >> 16);
         acc = 64'd1 << 30;
         for (int b = 0; b < 16; b++) begin
            if (f[15-b]) acc = (acc * roots[b]) >> 30;
         end
         g = (sh < 63) ? ((acc + (64'd1 << (sh - 1))) >> sh) : 64'd0;
         t[i] = (g > 64'd32767) ? GAIN_UNITY : g[15:0];
      end
      return t;
   endfunction

   localparam gain_table_type GAIN_TABLE = build_gain_table();

endpackage

[rtl/pvm_req_if.sv]
// request channel of the pcm voice mixer: valid, ready and one request beat
// no dependencies
interface pvm_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [4:0]        voice;
   logic [12:0]       sample_index;
   logic signed [15:0] sample_value;
   logic [13:0]       voice_length;
   logic signed [15:0] music_left;
   logic signed [15:0] music_right;
   logic              chunk_start;
   logic [23:0]       fade_frames;

   modport source (output valid, req_type, voice, sample_index, sample_value, voice_length,
                   music_left, music_right, chunk_start, fade_frames, input ready);
   modport sink (input valid, req_type, voice, sample_index, sample_value, voice_length,
                 music_left, music_right, chunk_start, fade_frames, output ready);
endinterface

[rtl/pvm_rsp_if.sv]
// response channel of the pcm voice mixer: valid, ready and one frame beat
// no dependencies
interface pvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_left;
   logic signed [15:0] out_right;
   logic [24:0]        music_next_pos;
   logic               music_seek;
   logic               music_active;

   modport source (output valid, out_left, out_right, music_next_pos, music_seek,
                   music_active, input ready);
   modport sink (input valid, out_left, out_right, music_next_pos, music_seek,
                 music_active, output ready);
endinterface

[rtl/pvm_csr.sv]
// apb-style register block: loop points, looping and sound enable
// depends on pvm_pkg
module pvm_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready,
   output pvm_pkg::cfg_type cfg
);
   import pvm_pkg::*;

   cfg_type cfg_ff;
   logic    wr;

   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_start   <= '0;
         cfg_ff.loop_end     <= '0;
         cfg_ff.looping      <= 1'b0;
         cfg_ff.sound_enable <= 1'b1;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_LOOP_START:   cfg_ff.loop_start   <= pwdata[POS_BITS-1:0];
            REG_LOOP_END:     cfg_ff.loop_end     <= pwdata[POS_BITS-1:0];
            REG_LOOPING:      cfg_ff.looping      <= pwdata[0];
            REG_SOUND_ENABLE: cfg_ff.sound_enable <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LOOP_START:   prdata = {{(32-POS_BITS){1'b0}}, cfg_ff.loop_start};
         REG_LOOP_END:     prdata = {{(32-POS_BITS){1'b0}}, cfg_ff.loop_end};
         REG_LOOPING:      prdata = {31'd0, cfg_ff.looping};
         REG_SOUND_ENABLE: prdata = {31'd0, cfg_ff.sound_enable};
      endcase
   end
endmodule

[rtl/pvm_front.sv]
// front end: accepts request beats, decodes the request code, clamps lengths
// depends on pvm_pkg and pvm_req_if
module pvm_front (
   pvm_req_if.sink         req,
   input  logic            q_full,
   output logic            q_push,
   output pvm_pkg::cmd_type q_data
);
   import pvm_pkg::*;

   op_type op;

   always_comb begin
      unique case (req.req_type)
         REQ_LOAD:        op = OP_LOAD;
         REQ_LENGTH:      op = OP_LENGTH;
         REQ_TRIGGER:     op = OP_TRIGGER;
         REQ_TICK:        op = OP_TICK;
         REQ_MUSIC_START: op = OP_MUSIC_START;
         REQ_MUSIC_STOP:  op = OP_MUSIC_STOP;
         REQ_FADE_START:  op = OP_FADE_START;
         default:         op = OP_NONE;
      endcase
   end

   assign req.ready = !q_full;
   // unknown codes are consumed and dropped here
   assign q_push    = req.valid && !q_full && (op != OP_NONE);

   always_comb begin
      q_data.op    = op;
      q_data.voice = req.voice;
      q_data.sidx  = req.sample_index;
      q_data.sval  = req.sample_value;
      q_data.vlen  = (req.voice_length > LEN_BITS'(VOICE_DEPTH)) ?
                     LEN_BITS'(VOICE_DEPTH) : req.voice_length;
      q_data.ml    = req.music_left;
      q_data.mr    = req.music_right;
      q_data.chunk = req.chunk_start;
      q_data.fade  = req.fade_frames;
   end
endmodule

[rtl/pvm_queue.sv]
// two-entry command queue between the front end and the mixing engine
// depends on pvm_pkg
module pvm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pvm_pkg::cmd_type push_data,
   input  logic             pop,
   output pvm_pkg::cmd_type pop_data,
   output logic             full,
   output logic             empty
);
   import pvm_pkg::*;

   cmd_type    mem_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[rtl/pvm_back.sv]
// mixing engine: sample store, voice sweep, fade divider, music scaling, output register
// depends on pvm_pkg and pvm_rsp_if
module pvm_back (
   input  logic             clock,
   input  logic             reset,
   input  pvm_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  pvm_pkg::cmd_type q_data,
   output logic             q_pop,
   pvm_rsp_if.source        rsp
);
   import pvm_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type cur_ff, cur_in;

   logic [LEN_BITS-1:0]   len_ff [NUM_VOICES];
   logic [LEN_BITS-1:0]   len_in [NUM_VOICES];
   logic [LEN_BITS-1:0]   pos_ff [NUM_VOICES];
   logic [LEN_BITS-1:0]   pos_in [NUM_VOICES];
   logic [NUM_VOICES-1:0] play_ff, play_in;
   logic [VOICE_BITS-1:0] pend_ff [PENDING_DEPTH];
   logic [VOICE_BITS-1:0] pend_in [PENDING_DEPTH];
   logic [PCNT_BITS-1:0]  pcnt_ff, pcnt_in;
   logic                  act_ff, act_in;

   logic [POS_BITS-1:0]   mpos_ff, mpos_in;
   logic                  mon_ff, mon_in;
   logic [FADE_BITS-1:0]  flen_ff, flen_in;
   logic [FADE_BITS-1:0]  fprog_ff, fprog_in;
   logic [15:0]           gain_ff, gain_in;

   logic [VOICE_BITS-1:0] vidx_ff, vidx_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [FADE_BITS-1:0]  rem_ff, rem_in;
   logic [GAIN_BITS-1:0]  quo_ff, quo_in;
   logic signed [VSUM_BITS-1:0] vsum_ff, vsum_in;
   logic signed [PROD_BITS-1:0] prodl_ff, prodl_in, prodr_ff, prodr_in;
   logic                  rdv_ff, rdv_in;

   logic signed [15:0]    resl_ff, resl_in, resr_ff, resr_in;
   logic                  seek_ff, seek_in;
   logic                  ov_ff, ov_in;
   logic signed [15:0]    ol_ff, ol_in, or_ff, or_in;
   logic [POS_BITS-1:0]   opos_ff, opos_in;
   logic                  oseek_ff, oseek_in, oact_ff, oact_in;

   logic signed [15:0]    store [STORE_DEPTH];
   logic signed [15:0]    mem_q_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_BITS-1:0]  mem_waddr, mem_raddr;

   logic [LEN_BITS-1:0]   cl, cp, np;
   logic                  cplay, match, dup;
   logic [FADE_BITS:0]    r2;
   logic signed [SUM_BITS-1:0] suml, sumr;
   logic [POS_BITS-1:0]   mp1;

   function automatic logic signed [15:0] sat_div(logic signed [SUM_BITS-1:0] s);
      logic signed [SUM_BITS-1:0] t;
      t = (s + (s[SUM_BITS-1] ? SUM_BITS'(32767) : SUM_BITS'(0))) >>> 15;
      if (t > SUM_BITS'(32767)) return 16'sh7fff;
      else if (t < -SUM_BITS'(32768)) return 16'sh8000;
      else return t[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_waddr] <= q_data.sval;
      if (mem_re) mem_q_ff <= store[mem_raddr];
   end

   assign rsp.valid          = ov_ff;
   assign rsp.out_left       = ol_ff;
   assign rsp.out_right      = or_ff;
   assign rsp.music_next_pos = opos_ff;
   assign rsp.music_seek     = oseek_ff;
   assign rsp.music_active   = oact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_VOICES; i++) begin
            len_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         play_ff <= '0;
         for (int p = 0; p < PENDING_DEPTH; p++) pend_ff[p] <= '0;
         pcnt_ff  <= '0;
         act_ff   <= 1'b0;
         mpos_ff  <= '0;
         mon_ff   <= 1'b0;
         flen_ff  <= '0;
         fprog_ff <= '0;
         gain_ff  <= GAIN_UNITY;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         play_ff  <= play_in;
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         act_ff   <= act_in;
         mpos_ff  <= mpos_in;
         mon_ff   <= mon_in;
         flen_ff  <= flen_in;
         fprog_ff <= fprog_in;
         gain_ff  <= gain_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      vidx_ff  <= vidx_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      vsum_ff  <= vsum_in;
      prodl_ff <= prodl_in;
      prodr_ff <= prodr_in;
      resl_ff  <= resl_in;
      resr_ff  <= resr_in;
      seek_ff  <= seek_in;
      ol_ff    <= ol_in;
      or_ff    <= or_in;
      opos_ff  <= opos_in;
      oseek_ff <= oseek_in;
      oact_ff  <= oact_in;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      play_in  = play_ff;
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      act_in   = act_ff;
      mpos_in  = mpos_ff;
      mon_in   = mon_ff;
      flen_in  = flen_ff;
      fprog_in = fprog_ff;
      gain_in  = gain_ff;
      vidx_in  = vidx_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      vsum_in  = vsum_ff;
      prodl_in = prodl_ff;
      prodr_in = prodr_ff;
      rdv_in   = 1'b0;
      resl_in  = resl_ff;
      resr_in  = resr_ff;
      seek_in  = seek_ff;
      ov_in    = ov_ff && !rsp.ready;
      ol_in    = ol_ff;
      or_in    = or_ff;
      opos_in  = opos_ff;
      oseek_in = oseek_ff;
      oact_in  = oact_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_waddr = {q_data.voice, q_data.sidx};
      mem_raddr = '0;
      cl = len_ff[vidx_ff];
      cp = pos_ff[vidx_ff];
      cplay = play_ff[vidx_ff];
      np = '0;
      match = 1'b0;
      dup = 1'b0;
      r2 = {rem_ff, 1'b0};
      suml = '0;
      sumr = '0;
      mp1 = mpos_ff + POS_BITS'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               unique case (q_data.op)
                  OP_LOAD: begin
                     mem_we    = 1'b1;
                     mem_waddr = {q_data.voice, q_data.sidx};
                  end
                  OP_LENGTH: begin
                     len_in[q_data.voice]  = q_data.vlen;
                     pos_in[q_data.voice]  = '0;
                     play_in[q_data.voice] = 1'b0;
                  end
                  OP_TRIGGER: begin
                     for (int p = 0; p < PENDING_DEPTH; p++) begin
                        if ((PCNT_BITS'(p) < pcnt_ff) && (pend_ff[p] == q_data.voice))
                           dup = 1'b1;
                     end
                     if (cfg.sound_enable && !dup && (pcnt_ff < PCNT_BITS'(PENDING_DEPTH))) begin
                        pend_in[pcnt_ff[PCNT_BITS-1:0]] = q_data.voice;
                        pcnt_in = pcnt_ff + PCNT_BITS'(1);
                     end
                  end
                  OP_MUSIC_START: begin
                     mon_in   = 1'b1;
                     mpos_in  = '0;
                     flen_in  = '0;
                     fprog_in = '0;
                     gain_in  = GAIN_UNITY;
                  end
                  OP_MUSIC_STOP: mon_in = 1'b0;
                  OP_FADE_START: begin
                     if (mon_ff) begin
                        flen_in  = q_data.fade;
                        fprog_in = '0;
                     end
                  end
                  OP_TICK: begin
                     act_in  = q_data.chunk && cfg.sound_enable;
                     vidx_in = '0;
                     vsum_in = '0;
                     seek_in = 1'b0;
                     state_in = ST_VOICE;
                     if (q_data.chunk && mon_ff) begin
                        if (flen_ff != '0 && fprog_ff >= flen_ff) begin
                           mon_in = 1'b0;
                        end else if (flen_ff != '0) begin
                           rem_in   = fprog_ff;
                           quo_in   = '0;
                           step_in  = '0;
                           state_in = ST_DIV;
                        end else begin
                           gain_in = GAIN_UNITY;
                        end
                     end
                  end
                  OP_NONE: ;
               endcase
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (r2 >= {1'b0, flen_ff}) begin
               rem_in = FADE_BITS'(r2 - {1'b0, flen_ff});
               quo_in = {quo_ff[GAIN_BITS-2:0], 1'b1};
            end else begin
               rem_in = r2[FADE_BITS-1:0];
               quo_in = {quo_ff[GAIN_BITS-2:0], 1'b0};
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(GAIN_BITS - 1)) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = GAIN_TABLE[quo_ff];
            state_in = ST_VOICE;
         end
         ST_VOICE: begin
            if (rdv_ff) vsum_in = vsum_ff + VSUM_BITS'(mem_q_ff);
            for (int p = 0; p < PENDING_DEPTH; p++) begin
               if ((PCNT_BITS'(p) < pcnt_ff) && (pend_ff[p] == vidx_ff)) match = 1'b1;
            end
            if (act_ff && match && cl != '0) begin
               cp = '0;
               cplay = 1'b1;
            end
            if (cplay) begin
               if (cp < cl) begin
                  mem_re    = 1'b1;
                  mem_raddr = {vidx_ff, cp[SIDX_BITS-1:0]};
                  rdv_in    = 1'b1;
                  np        = cp + LEN_BITS'(1);
                  pos_in[vidx_ff]  = np;
                  play_in[vidx_ff] = (np < cl);
               end else begin
                  pos_in[vidx_ff]  = cp;
                  play_in[vidx_ff] = 1'b0;
               end
            end
            vidx_in = vidx_ff + VOICE_BITS'(1);
            if (vidx_ff == VOICE_BITS'(NUM_VOICES - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rdv_ff) vsum_in = vsum_ff + VSUM_BITS'(mem_q_ff);
            if (act_ff) pcnt_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mon_ff) begin
               prodl_in = PROD_BITS'(cur_ff.ml * $signed({1'b0, gain_ff}));
               prodr_in = PROD_BITS'(cur_ff.mr * $signed({1'b0, gain_ff}));
            end else begin
               prodl_in = '0;
               prodr_in = '0;
            end
            state_in = ST_SAT;
         end
         ST_SAT: begin
            suml = (SUM_BITS'(vsum_ff) <<< 15) + SUM_BITS'(prodl_ff);
            sumr = (SUM_BITS'(vsum_ff) <<< 15) + SUM_BITS'(prodr_ff);
            resl_in = sat_div(suml);
            resr_in = sat_div(sumr);
            if (mon_ff) begin
               if (flen_ff != '0 && fprog_ff < FADE_MAX) fprog_in = fprog_ff + FADE_BITS'(1);
               mpos_in = mp1;
               if (mp1 == cfg.loop_end) begin
                  if (cfg.looping) begin
                     mpos_in = cfg.loop_start;
                     seek_in = 1'b1;
                  end else begin
                     mon_in = 1'b0;
                  end
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in    = 1'b1;
               ol_in    = resl_ff;
               or_in    = resr_ff;
               opos_in  = mpos_ff;
               oseek_in = seek_ff;
               oact_in  = mon_ff;
               state_in = ST_IDLE;
            end
         end
      endcase
   end
endmodule

[rtl/pcm_voice_mixer_with_looping_music.sv]
// tick path: from the queue head the sample store is swept one voice per cycle, then the
// drain, multiply and saturate states load the output register; a fade gain is resolved
// first by the divider; other requests are handled in the idle state; the front end queues
// two beats ahead; synchronous active-high reset clears the control state at once, but not
// the sweep and divider counters; the sample store is not cleared
// depends on pvm_pkg, pvm_req_if, pvm_rsp_if, pvm_csr, pvm_front, pvm_queue, pvm_back
module pcm_voice_mixer_with_looping_music (
   input  logic        clock,
   input  logic        reset,
   pvm_req_if.sink     req,
   pvm_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pvm_pkg::*;

   cfg_type cfg;
   cmd_type push_data, pop_data;
   logic    push, pop, full, empty;

   pvm_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   pvm_front u_front (
      .req, .q_full(full), .q_push(push), .q_data(push_data)
   );

   pvm_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .full, .empty
   );

   pvm_back u_back (
      .clock, .reset, .cfg, .q_empty(empty), .q_data(pop_data), .q_pop(pop), .rsp
   );
endmodule
